@@ hw/rtl/svpwm_top_bottom_compare_assert.svh @@
// ---------------------------------------------------------------------------
// svpwm_top_bottom_compare_assert.svh
// Assertion macros used by the SVPWM compare top level.
// ---------------------------------------------------------------------------
`ifndef SVPWM_TOP_BOTTOM_COMPARE_ASSERT_SVH
`define SVPWM_TOP_BOTTOM_COMPARE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define SVPWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("svpwm: same-cycle check failed");

// next-cycle implication, quiet during reset
`define SVPWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("svpwm: next-cycle check failed");

// next-cycle implication, live through reset
`define SVPWM_ASSERT_ALW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("svpwm: reset check failed");

`endif

@@ hw/rtl/svpwm_pkg.sv @@
// ---------------------------------------------------------------------------
// svpwm_pkg
// Types, Q24 constants and helpers for the SVPWM compare pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package svpwm_pkg;

    localparam logic [31:0] Q_ONE      = 32'h0100_0000;
    localparam logic [31:0] Q_HALF     = 32'h0080_0000;
    localparam logic [31:0] Q_TWO      = 32'h0200_0000;
    localparam logic [31:0] SQRT3_HALF = 32'd14529495;

    // sector codes
    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;
    localparam logic [2:0] SEC_6 = 3'd6;
    localparam logic [2:0] SEC_7 = 3'd7;

    typedef struct packed {
        logic        shutdown;
        logic [31:0] alpha_ref;
        logic [31:0] beta_ref;
        logic [31:0] dc_offset;
        logic [31:0] gain;
    } t_svpwm_in;

    typedef struct packed {
        logic [31:0] leg1_top;
        logic [31:0] leg1_bottom;
        logic [31:0] leg2_top;
        logic [31:0] leg2_bottom;
        logic [31:0] leg3_top;
        logic [31:0] leg3_bottom;
    } t_svpwm_out;

    // after sector decode
    typedef struct packed {
        logic        shutdown;
        logic [2:0]  sector;
        logic [31:0] va;
        logic [31:0] vb;
        logic [31:0] vc;
        logic [31:0] dc_offset;
        logic [31:0] gain;
    } t_sec_data;

    // duty terms ready for scaling: dm = d - 1.0, dp = d + 1.0
    typedef struct packed {
        logic            shutdown;
        logic [2:0][31:0] dm;
        logic [2:0][31:0] dp;
        logic [31:0]     gain;
    } t_duty_data;

    function automatic logic [31:0] asr1(input logic [31:0] u);
        asr1 = {u[31], u[31:1]};
    endfunction

    // Q24 product: floor(p / 2^24), low 32 bits
    function automatic logic [31:0] q24_take(input logic [63:0] p);
        q24_take = p[55:24];
    endfunction

    function automatic logic is_pos(input logic [31:0] u);
        is_pos = (u != 32'd0) && !u[31];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/svpwm_sector.sv @@
// ---------------------------------------------------------------------------
// svpwm_sector
// Two stages: alpha projection multiply, then projected voltages and sector.
// ---------------------------------------------------------------------------
`default_nettype none

module svpwm_sector (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  svpwm_pkg::t_svpwm_in   i_data,
    output logic                   o_valid,
    input  wire                    i_ready,
    output svpwm_pkg::t_sec_data   o_data
);
    import svpwm_pkg::*;

    // stage A
    logic        r_va_valid;
    logic        r_a_sd;
    logic [31:0] r_a_ka;
    logic [31:0] r_a_kb;
    logic [31:0] r_a_be;
    logic [31:0] r_a_dc;
    logic [31:0] r_a_gain;
    logic        w_a_ready;
    logic [63:0] w_prod;

    // stage B
    logic        r_vb_valid;
    t_sec_data   r_b;
    t_sec_data   n_b;
    logic        w_b_ready;
    logic [31:0] w_pb;
    logic [31:0] w_pc;

    assign w_b_ready = !r_vb_valid || i_ready;
    assign w_a_ready = !r_va_valid || w_b_ready;
    assign o_ready   = w_a_ready;

    assign w_prod = 64'($signed(i_data.alpha_ref) * $signed(SQRT3_HALF));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va_valid <= 1'b0;
        end else if (w_a_ready) begin
            r_va_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_valid) begin
            r_a_sd   <= i_data.shutdown;
            r_a_ka   <= q24_take(w_prod);
            r_a_kb   <= asr1(i_data.beta_ref);
            r_a_be   <= i_data.beta_ref;
            r_a_dc   <= i_data.dc_offset;
            r_a_gain <= i_data.gain;
        end
    end

    // projections for the sector test
    assign w_pb = r_a_ka - r_a_kb;
    assign w_pc = 32'd0 - r_a_ka - r_a_kb;

    always_comb begin
        n_b.shutdown  = r_a_sd;
        n_b.sector    = {is_pos(w_pc), is_pos(w_pb), is_pos(r_a_be)};
        n_b.va        = r_a_be;
        n_b.vb        = r_a_ka + r_a_kb;
        n_b.vc        = r_a_kb - r_a_ka;
        n_b.dc_offset = r_a_dc;
        n_b.gain      = r_a_gain;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb_valid <= 1'b0;
        end else if (w_b_ready) begin
            r_vb_valid <= r_va_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_ready && r_va_valid) begin
            r_b <= n_b;
        end
    end

    assign o_valid = r_vb_valid;
    assign o_data  = r_b;

endmodule

`default_nettype wire

@@ hw/rtl/svpwm_duty.sv @@
// ---------------------------------------------------------------------------
// svpwm_duty
// Two stages: per-sector phase duties, then offset duty terms around 1.0.
// ---------------------------------------------------------------------------
`default_nettype none

module svpwm_duty (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  svpwm_pkg::t_sec_data   i_data,
    output logic                   o_valid,
    input  wire                    i_ready,
    output svpwm_pkg::t_duty_data  o_data
);
    import svpwm_pkg::*;

    // stage C
    logic             r_vc_valid;
    logic             r_c_sd;
    logic [2:0][31:0] r_c_t;
    logic [31:0]      r_c_dc;
    logic [31:0]      r_c_gain;
    logic [2:0][31:0] n_t;
    logic             w_c_ready;
    logic [31:0]      w_va;
    logic [31:0]      w_vb;
    logic [31:0]      w_vc;

    // stage D
    logic             r_vd_valid;
    t_duty_data       r_d;
    t_duty_data       n_d;
    logic             w_d_ready;

    assign w_d_ready = !r_vd_valid || i_ready;
    assign w_c_ready = !r_vc_valid || w_d_ready;
    assign o_ready   = w_c_ready;

    assign w_va = i_data.va;
    assign w_vb = i_data.vb;
    assign w_vc = i_data.vc;

    // n_t[0..2] = ta, tb, tc
    always_comb begin
        n_t = '0;
        unique case (i_data.sector)
            SEC_1: begin
                n_t[1] = asr1(Q_ONE - w_vc - w_vb);
                n_t[0] = n_t[1] + w_vc;
                n_t[2] = n_t[0] + w_vb;
            end
            SEC_2: begin
                n_t[0] = asr1(Q_ONE - w_vb + w_va);
                n_t[2] = n_t[0] + w_vb;
                n_t[1] = n_t[2] - w_va;
            end
            SEC_3: begin
                n_t[0] = asr1(Q_ONE + w_vc - w_va);
                n_t[1] = n_t[0] - w_vc;
                n_t[2] = n_t[1] + w_va;
            end
            SEC_4: begin
                n_t[2] = asr1(Q_ONE + w_va - w_vc);
                n_t[1] = n_t[2] - w_va;
                n_t[0] = n_t[1] + w_vc;
            end
            SEC_5: begin
                n_t[1] = asr1(Q_ONE - w_va + w_vb);
                n_t[2] = n_t[1] + w_va;
                n_t[0] = n_t[2] - w_vb;
            end
            SEC_6: begin
                n_t[2] = asr1(Q_ONE + w_vb + w_vc);
                n_t[0] = n_t[2] - w_vb;
                n_t[1] = n_t[0] - w_vc;
            end
            SEC_0, SEC_7: begin
                n_t[0] = Q_HALF;
                n_t[1] = Q_HALF;
                n_t[2] = Q_HALF;
            end
            default: begin
                n_t[0] = Q_HALF;
                n_t[1] = Q_HALF;
                n_t[2] = Q_HALF;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc_valid <= 1'b0;
        end else if (w_c_ready) begin
            r_vc_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_c_ready && i_valid) begin
            r_c_sd   <= i_data.shutdown;
            r_c_t    <= n_t;
            r_c_dc   <= i_data.dc_offset;
            r_c_gain <= i_data.gain;
        end
    end

    // d = 1.0 - 2t + dc; dm = d - 1.0, dp = d + 1.0
    always_comb begin
        n_d.shutdown = r_c_sd;
        n_d.gain     = r_c_gain;
        for (int i = 0; i < 3; i++) begin
            n_d.dm[i] = r_c_dc - {r_c_t[i][30:0], 1'b0};
            n_d.dp[i] = r_c_dc - {r_c_t[i][30:0], 1'b0} + Q_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd_valid <= 1'b0;
        end else if (w_d_ready) begin
            r_vd_valid <= r_vc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_d_ready && r_vc_valid) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_vd_valid;
    assign o_data  = r_d;

endmodule

`default_nettype wire

@@ hw/rtl/svpwm_scale.sv @@
// ---------------------------------------------------------------------------
// svpwm_scale
// Two stages: six Q24 gain multiplies, then compare values and output reg.
// ---------------------------------------------------------------------------
`default_nettype none

module svpwm_scale (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  svpwm_pkg::t_duty_data  i_data,
    output logic                   o_valid,
    input  wire                    i_ready,
    output svpwm_pkg::t_svpwm_out  o_data
);
    import svpwm_pkg::*;

    // stage E
    logic             r_ve_valid;
    logic             r_e_sd;
    logic [2:0][31:0] r_e_mt;
    logic [2:0][31:0] r_e_mb;
    logic [2:0][31:0] n_mt;
    logic [2:0][31:0] n_mb;
    logic             w_e_ready;

    // stage F (output register)
    logic             r_vf_valid;
    t_svpwm_out       r_f;
    t_svpwm_out       n_f;
    logic             w_f_ready;
    logic [2:0][31:0] w_top;
    logic [2:0][31:0] w_bot;

    assign w_f_ready = !r_vf_valid || i_ready;
    assign w_e_ready = !r_ve_valid || w_f_ready;
    assign o_ready   = w_e_ready;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mt[i] = q24_take(64'($signed(i_data.gain) * $signed(i_data.dm[i])));
            n_mb[i] = q24_take(64'($signed(i_data.gain) * $signed(i_data.dp[i])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve_valid <= 1'b0;
        end else if (w_e_ready) begin
            r_ve_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_e_ready && i_valid) begin
            r_e_sd <= i_data.shutdown;
            r_e_mt <= n_mt;
            r_e_mb <= n_mb;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_top[i] = r_e_sd ? Q_ONE : Q_ONE + asr1(r_e_mt[i]);
            w_bot[i] = r_e_sd ? Q_ONE : asr1(r_e_mb[i]) - Q_ONE;
        end
        n_f.leg1_top    = w_top[0];
        n_f.leg1_bottom = w_bot[0];
        n_f.leg2_top    = w_top[1];
        n_f.leg2_bottom = w_bot[1];
        n_f.leg3_top    = w_top[2];
        n_f.leg3_bottom = w_bot[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf_valid <= 1'b0;
        end else if (w_f_ready) begin
            r_vf_valid <= r_ve_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_f_ready && r_ve_valid) begin
            r_f <= n_f;
        end
    end

    assign o_valid = r_vf_valid;
    assign o_data  = r_f;

endmodule

`default_nettype wire

@@ hw/rtl/svpwm_top_bottom_compare.sv @@
// ---------------------------------------------------------------------------
// svpwm_top_bottom_compare
// Sector-based space vector PWM: top and bottom compare values for 3 legs.
// ---------------------------------------------------------------------------
// Takes one reference sample per transaction (alpha/beta in signed Q24, DC
// offset, gain, shutdown) and returns one transaction of six signed Q24
// compare values. Six register stages, each a valid/ready slot: alpha
// projection multiply; projected voltages and sector; per-sector duties;
// duty terms around 1.0; six 32x32 gain multiplies; compare values into the
// output register. A new transaction is taken every cycle while the output
// side keeps up, so throughput is one per clock. A stalled output backs up
// through the slots one at a time; input ready falls only once every slot is
// full. Shutdown forces all six outputs to 1.0. Sector zero and sector seven,
// which only wrap-around reaches, give 0.5 duties. All sums wrap at 32 bits;
// Q24 products round toward minus infinity. No state beyond the pipeline;
// reset only empties it.
// ---------------------------------------------------------------------------
`default_nettype none

`include "svpwm_top_bottom_compare_assert.svh"

module svpwm_top_bottom_compare (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  svpwm_pkg::t_svpwm_in   i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output svpwm_pkg::t_svpwm_out  o_out_data
);
    import svpwm_pkg::*;

    // sector -> duty handshake
    logic       w_sec_valid;
    logic       w_duty_ready;
    t_sec_data  w_sec_data;

    // duty -> scale handshake
    logic       w_duty_valid;
    logic       w_scale_ready;
    t_duty_data w_duty_data;

    // front end: sqrt(3)/2 projection and sector pick
    svpwm_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (w_sec_valid),
        .i_ready (w_duty_ready),
        .o_data  (w_sec_data)
    );

    // per-sector duty formula plus DC offset
    svpwm_duty u_duty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sec_valid),
        .o_ready (w_duty_ready),
        .i_data  (w_sec_data),
        .o_valid (w_duty_valid),
        .i_ready (w_scale_ready),
        .o_data  (w_duty_data)
    );

    // gain scaling, compare values, output register
    svpwm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_duty_valid),
        .o_ready (w_scale_ready),
        .i_data  (w_duty_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    // pipeline empties on reset
    `SVPWM_ASSERT_ALW(a_rst_empty, i_clk, !i_rst_n, !o_out_valid)
    // a transaction held in the duty slot is never dropped while scale stalls
    `SVPWM_ASSERT_NXT(a_duty_hold, i_clk, i_rst_n, w_duty_valid && !w_scale_ready, w_duty_valid)
    // when the output is taken every slot can move, so the input must be open
    `SVPWM_ASSERT_IMP(a_flow_open, i_clk, i_rst_n, o_out_valid && i_out_ready, o_in_ready)

endmodule

`default_nettype wire

@@ sim/svpwm_top_bottom_compare_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svpwm_top_bottom_compare_test
// Self-checking bench for the sector-based SVPWM compare pipeline.
// ---------------------------------------------------------------------------
// Each reference sample is predicted in the bench: sector decode, per-sector
// duties, offset and Q24 gain scaling, with every sum wrapping at 32 bits.
// Predicted compare sets wait in a queue and every output transaction is
// checked field by field against the oldest one. Directed samples cover
// shutdown, sector zero, all six live sectors, the wrapped sector seven and
// the field extremes; random samples follow, most of them realistic
// references and the rest full-range noise. The sender runs in bursts, the
// receiver stalls on its own pattern, and one long receiver hold-off backs
// the pipeline up until its input stalls.
// ---------------------------------------------------------------------------

module svpwm_top_bottom_compare_test;

    import svpwm_pkg::*;

    localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
    localparam int DRAIN_CYCLES = 16;   // six-stage pipeline plus margin
    localparam int MAX_PRINTS   = 50;

    // receiver stall behaviour, re-chosen every so often
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_PATTERN,
        RX_MOSTLY,
        RX_SPARSE
    } rx_mode_e;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_svpwm_in   in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_svpwm_out  out_data;

    // predicted compare sets, oldest first
    t_svpwm_out  expected_compares[$];

    int          error_count    = 0;
    int          checked_count  = 0;
    int          sample_count   = 0;
    int          shutdown_count = 0;
    int          sector_hits[8];
    int          longest_stall  = 0;

    // sender burst state
    int          burst_left     = 0;

    // hold-off handshake between the pressure test and its counter
    logic        hold_req       = 1'b0;
    logic        hold_active    = 1'b0;

    // receiver pattern state
    rx_mode_e    rx_mode        = RX_ALWAYS;
    int          mode_left      = 0;
    logic [7:0]  rx_mask        = 8'hff;

    svpwm_top_bottom_compare dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Compare-value predictor
    // ------------------------------------------------------------------

    // Q24 product: full 64-bit signed product, floor shift by 24, low word
    function automatic logic [31:0] q24_product(input logic [31:0] a,
                                                input logic [31:0] b);
        logic signed [63:0] prod;
        logic signed [63:0] shifted;
        prod    = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        shifted = prod >>> 24;
        return shifted[31:0];
    endfunction

    function automatic logic [31:0] halve(input logic [31:0] u);
        return $unsigned($signed(u) >>> 1);
    endfunction

    function automatic logic strictly_pos(input logic [31:0] u);
        return !u[31] && (u != 32'd0);
    endfunction

    function automatic t_svpwm_out predict_compares(input  t_svpwm_in  s,
                                                    output logic [2:0] sector);
        t_svpwm_out  res;
        logic [31:0] ka, kb, va, vb, vc, ta, tb, tc, duty;
        logic [31:0] t [3];
        logic [31:0] top [3];
        logic [31:0] bot [3];

        sector = SEC_0;
        if (s.shutdown) begin
            res = {6{Q_ONE}};
            return res;
        end

        // projected voltages pick the sector
        ka = q24_product(s.alpha_ref, SQRT3_HALF);
        kb = halve(s.beta_ref);
        va = s.beta_ref;
        vb = ka - kb;
        vc = 32'd0 - ka - kb;
        sector = {strictly_pos(vc), strictly_pos(vb), strictly_pos(va)};

        // the duty formulas use the rotated pair
        vb = ka + kb;
        vc = kb - ka;

        case (sector)
            SEC_1: begin
                tb = halve(Q_ONE - vc - vb);
                ta = tb + vc;
                tc = ta + vb;
            end
            SEC_2: begin
                ta = halve(Q_ONE - vb + va);
                tc = ta + vb;
                tb = tc - va;
            end
            SEC_3: begin
                ta = halve(Q_ONE + vc - va);
                tb = ta - vc;
                tc = tb + va;
            end
            SEC_4: begin
                tc = halve(Q_ONE + va - vc);
                tb = tc - va;
                ta = tb + vc;
            end
            SEC_5: begin
                tb = halve(Q_ONE - va + vb);
                tc = tb + va;
                ta = tc - vb;
            end
            SEC_6: begin
                tc = halve(Q_ONE + vb + vc);
                ta = tc - vb;
                tb = ta - vc;
            end
            default: begin
                // sector zero and the wrapped sector seven: flat half duty
                ta = Q_HALF;
                tb = Q_HALF;
                tc = Q_HALF;
            end
        endcase

        t[0] = ta;
        t[1] = tb;
        t[2] = tc;
        for (int i = 0; i < 3; i++) begin
            duty   = Q_ONE - (t[i] << 1) + s.dc_offset;
            top[i] = Q_ONE + halve(q24_product(s.gain, duty - Q_ONE));
            bot[i] = halve(q24_product(s.gain, duty + Q_ONE)) - Q_ONE;
        end
        res = {top[0], bot[0], top[1], bot[1], top[2], bot[2]};
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTS)
            $display("%0t ns: mismatch on %s: got %08h, expected %08h",
                     $realtime, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender: one transaction per call, bursts with random gaps between
    // ------------------------------------------------------------------

    task automatic send_sample(input t_svpwm_in s);
        int         gap;
        int         stall;
        logic [2:0] sector;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        // ready is settled by the falling edge; the next rising edge takes it
        stall = 0;
        @(negedge clk);
        while (!in_ready) begin
            stall++;
            @(negedge clk);
        end
        @(posedge clk);
        if (stall > longest_stall)
            longest_stall = stall;
        expected_compares.push_back(predict_compares(s, sector));
        sample_count++;
        if (s.shutdown)
            shutdown_count++;
        else
            sector_hits[sector]++;
        burst_left--;
    endtask

    function automatic t_svpwm_in make_sample(input logic        shutdown,
                                              input logic [31:0] alpha,
                                              input logic [31:0] beta,
                                              input logic [31:0] dc,
                                              input logic [31:0] gain);
        t_svpwm_in s;
        s.shutdown  = shutdown;
        s.alpha_ref = alpha;
        s.beta_ref  = beta;
        s.dc_offset = dc;
        s.gain      = gain;
        return s;
    endfunction

    // uniform signed value in [-span, span]
    function automatic logic [31:0] rand_signed(input int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // realistic reference: inside about 1.5 in Q24, modest offset and gain
    function automatic t_svpwm_in rand_reference();
        return make_sample($urandom_range(0, 11) == 0,
                           rand_signed(32'd25165824), rand_signed(32'd25165824),
                           rand_signed(32'd4194304), rand_signed(32'd33554432));
    endfunction

    // ------------------------------------------------------------------
    // Receiver: own stall pattern, overridden by the hold-off
    // ------------------------------------------------------------------

    always @(posedge clk) begin : receiver
        logic next_ready;
        if (mode_left == 0) begin
            rx_mode   <= rx_mode_e'($urandom_range(0, 3));
            mode_left <= $urandom_range(16, 160);
            rx_mask   <= 8'($urandom);
        end else begin
            mode_left <= mode_left - 1;
            rx_mask   <= {rx_mask[6:0], rx_mask[7]};
        end
        case (rx_mode)
            RX_ALWAYS:  next_ready = 1'b1;
            RX_PATTERN: next_ready = rx_mask[0];
            RX_MOSTLY:  next_ready = ($urandom_range(0, 3) != 0);
            default:    next_ready = ($urandom_range(0, 3) == 0);
        endcase
        out_ready <= next_ready && !hold_active;
    end

    // hold-off counter, switched on falling edges so the receiver sees a
    // settled value at the rising edge
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_active = 1'b0;
                hold_req    = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output checker: a transaction seen at the falling edge completes at
    // the next rising edge, since ready only moves on rising edges
    // ------------------------------------------------------------------

    string leg_fields [6] = '{"leg1_top", "leg1_bottom", "leg2_top",
                              "leg2_bottom", "leg3_top", "leg3_bottom"};

    always @(negedge clk) begin : output_check
        t_svpwm_out want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_compares.size() == 0) begin
                report_mismatch("unexpected transaction", out_data[191:160], 32'd0);
            end else begin
                want = expected_compares.pop_front();
                for (int i = 0; i < 6; i++)
                    if (out_data[191 - 32 * i -: 32] !== want[191 - 32 * i -: 32])
                        report_mismatch(leg_fields[i], out_data[191 - 32 * i -: 32],
                                        want[191 - 32 * i -: 32]);
                checked_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_shutdown();
        send_sample(make_sample(1'b1, $urandom, $urandom, $urandom, $urandom));
        send_sample(make_sample(1'b1, 32'h8000_0000, 32'h7fff_ffff,
                                32'h8000_0000, 32'h7fff_ffff));
        // back to normal straight after a shutdown
        send_sample(make_sample(1'b0, 32'd0, 32'd0, 32'd0, Q_ONE));
    endtask

    // one point in the middle of each live sector, magnitude 0.45
    task automatic test_sectors();
        real c [6] = '{0.866, 0.0, -0.866, -0.866, 0.0, 0.866};
        real s [6] = '{0.5, 1.0, 0.5, -0.5, -1.0, -0.5};
        for (int i = 0; i < 6; i++)
            send_sample(make_sample(1'b0, $rtoi(c[i] * 0.45 * 16777216.0),
                                    $rtoi(s[i] * 0.45 * 16777216.0),
                                    32'd0, Q_ONE));
    endtask

    task automatic test_wrap_and_extremes();
        // most negative alpha with most positive beta wraps into sector seven
        send_sample(make_sample(1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'd0, Q_ONE));
        send_sample(make_sample(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'd0, Q_ONE));
        send_sample(make_sample(1'b0, 32'h0040_0000, 32'h0020_0000,
                                32'h7fff_ffff, Q_ONE));
        send_sample(make_sample(1'b0, 32'h0040_0000, 32'h0020_0000,
                                32'h8000_0000, Q_ONE));
        send_sample(make_sample(1'b0, 32'hffc0_0000, 32'h0030_0000,
                                32'd0, 32'h7fff_ffff));
        send_sample(make_sample(1'b0, 32'hffc0_0000, 32'h0030_0000,
                                32'd0, 32'h8000_0000));
        send_sample(make_sample(1'b0, 32'h0050_0000, 32'hffb0_0000, 32'd0, 32'd0));
        send_sample(make_sample(1'b0, 32'h7fff_ffff, 32'h7fff_ffff,
                                32'h7fff_ffff, 32'h7fff_ffff));
        send_sample(make_sample(1'b0, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000));
        send_sample(make_sample(1'b0, 32'hffff_ffff, 32'hffff_ffff,
                                32'hffff_ffff, 32'hffff_ffff));
    endtask

    task automatic test_random_references(input int count);
        for (int i = 0; i < count; i++)
            send_sample(rand_reference());
    endtask

    // full-range noise: every bit of every field moves
    task automatic test_random_wide(input int count);
        for (int i = 0; i < count; i++)
            send_sample(make_sample($urandom_range(0, 3) == 0,
                                    $urandom, $urandom, $urandom, $urandom));
    endtask

    // receiver holds off while the sender keeps offering, so the slots fill
    // and input ready drops
    task automatic test_backpressure(input int count);
        // the last transaction is already taken; stop offering it again
        in_valid <= 1'b0;
        hold_req = 1'b1;
        wait (hold_active);
        @(posedge clk);
        for (int i = 0; i < count; i++)
            send_sample(rand_reference());
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_shutdown();
        test_sectors();
        test_wrap_and_extremes();
        test_random_references(800);
        test_backpressure(40);
        test_random_wide(300);

        in_valid <= 1'b0;
        while (expected_compares.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d samples (%0d shutdown), %0d compare sets checked, %0d errors",
                 sample_count, shutdown_count, checked_count, error_count);
        $display("sector hits 0-7: %0d %0d %0d %0d %0d %0d %0d %0d, longest input stall %0d",
                 sector_hits[0], sector_hits[1], sector_hits[2], sector_hits[3],
                 sector_hits[4], sector_hits[5], sector_hits[6], sector_hits[7],
                 longest_stall);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout with %0d compare sets outstanding", expected_compares.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
